>>> rtl/sha256_pkg.sv
// sha-256 package: round constants, initial hash, helper functions and queue entry type
// used by all sha256 modules; no dependencies
package sha256_pkg;

    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_item_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/sha256_message_digest.sv
// top level of the sha-256 streaming digest
// depends on sha256_pkg, sha256_queue, sha256_core
//
//  channel | dir | tdata                    | tuser         | tlast
//  s_axis  | in  | [7:0] data_byte          | byte_present  | end_of_message
//  m_axis  | out | [31:0] digest_word       | -             | last_word
//
// each byte is taken while the core is idle; a full block adds a 64-round compression and one add step
// a message end adds one or two pad loads, each followed by compression and add, then 8 output beats
// the queue keeps accepting input beats while the core compresses or outputs, until it is full
// reset is asynchronous, active low, and restores the initial hash
// the output holds each word until m_axis_tready is high
module sha256_message_digest
    import sha256_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast
);
    sha_item_t in_item, q_item;
    logic      q_valid, q_ready;

    assign in_item = '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
                       end_of_message: s_axis_tlast};

    sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_item  (in_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    sha256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .digest_word (m_axis_tdata),
        .last_word   (m_axis_tlast)
    );
endmodule

>>> rtl/sha256_queue.sv
// short item queue between the front and back parts
// depends on sha256_pkg
module sha256_queue
    import sha256_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  sha_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output sha_item_t rd_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_item_t         mem_reg [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr_en, rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) && !wr_en |=> (cnt_reg == '0))
        else $error("queue count moved without write");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH)) && !rd_en |=> !wr_ready)
        else $error("full queue became ready");
endmodule

>>> rtl/sha256_core.sv
// back part: block packing, padding, 64-round compression and digest output
// depends on sha256_pkg
module sha256_core
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  sha_item_t   item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        last_word
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] h_reg [8];
    logic [31:0] blk_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  t_reg;
    logic [2:0]  k_reg;
    logic        fin_reg;     // end pending after current compression
    logic        pad2_reg;    // second padding block pending
    logic        outv_reg;
    // set once a padding block has been loaded for the current message
    logic        pad_done_reg;

    logic [31:0] wt, g0, g1, t1, t2, s0, s1, ch, maj, x15, x2;

    always_comb
    begin
        x15 = w_reg[1];
        x2  = w_reg[14];
        g0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        g1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        wt  = w_reg[0];
        s1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + round_k(t_reg) + wt;
        s0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + maj;
    end

    assign item_ready  = (state_reg == ST_IDLE);
    assign out_valid   = outv_reg;
    assign digest_word = h_reg[k_reg];
    assign last_word   = (k_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && item.byte_present)
                begin
                    if (fill_reg[1:0] == 2'd0)
                    begin
                        blk_reg[fill_reg[5:2]] <= {item.data_byte, 24'd0};
                    end
                    else
                    begin
                        blk_reg[fill_reg[5:2]][(5'd3 - {3'd0, fill_reg[1:0]}) * 8 +: 8]
                            <= item.data_byte;
                    end
                end
                if (item_valid && item.byte_present && fill_reg == 6'd63)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= blk_reg[i];
                    end
                    w_reg[15] <= {blk_reg[15][31:8], item.data_byte};
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
            end
            ST_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if ((pad2_reg || fill_reg < 6'd56) && i == 14)
                    begin
                        w_reg[i] <= bits_reg[63:32];
                    end
                    else if ((pad2_reg || fill_reg < 6'd56) && i == 15)
                    begin
                        w_reg[i] <= bits_reg[31:0];
                    end
                    else if (pad2_reg)
                    begin
                        w_reg[i] <= '0;
                    end
                    else if (i == fill_reg[5:2])
                    begin
                        w_reg[i] <= (fill_reg[1:0] == 2'd0) ? 32'h8000_0000 :
                            (blk_reg[i] | (32'h80 << ((3 - fill_reg[1:0]) * 8)));
                    end
                    else if (i < fill_reg[5:2])
                    begin
                        w_reg[i] <= blk_reg[i];
                    end
                    else
                    begin
                        w_reg[i] <= '0;
                    end
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= w_reg[0] + g0 + w_reg[9] + g1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
            end
            fill_reg <= '0;
            bits_reg <= '0;
            t_reg    <= '0;
            k_reg    <= '0;
            fin_reg  <= 1'b0;
            pad2_reg <= 1'b0;
            outv_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        fin_reg <= item.end_of_message;
                        if (item.byte_present)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            bits_reg <= bits_reg + 64'd8;
                        end
                        t_reg <= '0;
                        if (item.byte_present && fill_reg == 6'd63)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else if (item.end_of_message)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    t_reg     <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    // decide next step: back to idle mid-message, or the next step of the message end sequence
                    if (!fin_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (!pad_done_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else if (pad2_reg || fill_reg < 6'd56)
                    begin
                        state_reg <= ST_OUT;
                        k_reg     <= '0;
                        outv_reg  <= 1'b1;
                    end
                    else
                    begin
                        pad2_reg  <= 1'b1;
                        state_reg <= ST_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        k_reg <= k_reg + 3'd1;
                        if (k_reg == 3'd7)
                        begin
                            outv_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                            fin_reg   <= 1'b0;
                            pad2_reg  <= 1'b0;
                            fill_reg  <= '0;
                            bits_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_hash(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_done_reg <= 1'b0;
        end
        else if (state_reg == ST_PAD)
        begin
            pad_done_reg <= 1'b1;
        end
        else if (state_reg == ST_ADD && fin_reg && !(pad2_reg || fill_reg < 6'd56)
                 && pad_done_reg)
        begin
            pad_done_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT)
        begin
            pad_done_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_OUT))
        else $error("digest shown outside output phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (t_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("round count did not end compression");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid && (fill_reg == '0))
        else $error("message state not cleared after digest");
endmodule

>>> sim/tb_sha256_message_digest.sv
// testbench for sha256_message_digest: directed and random byte streams with random end marks,
// digest words checked against a behavioral sha-256 predictor; depends on sha256_pkg
module tb_sha256_message_digest;
    import sha256_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // byte_present
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic        m_axis_tlast;   // last_word

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    sha_item_t    pending_items[$];
    digest_beat_t expected_words[$];

    logic [31:0] hash_state[8];
    logic [31:0] msg_block[16];
    logic [5:0]  fill_bytes;
    logic [63:0] bit_count;

    int mismatches;
    int words_checked;
    int messages_seen;
    bit quiet_phase;
    bit hold_sink;
    bit hold_go;
    bit hold_done;
    bit in_fire;
    int src_gap;
    int sink_gap;

    sha256_message_digest u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] x15, x2, t1, t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = msg_block[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_state[i];
        end
        for (int t = 0; t < 64; t++)
        begin
            if (t >= 16)
            begin
                x15 = w[(t - 15) & 15];
                x2 = w[(t - 2) & 15];
                w[t & 15] = w[t & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3))
                    + w[(t - 7) & 15] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t & 15];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
            begin
                v[i] = v[i - 1];
            end
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
        end
    endtask

    task automatic place_byte(logic [5:0] pos, logic [7:0] b);
        if (pos[1:0] == 2'd0)
        begin
            msg_block[pos[5:2]] = {b, 24'h0};
        end
        else
        begin
            msg_block[pos[5:2]] |= 32'(b) << ((3 - pos[1:0]) * 8);
        end
    endtask

    task automatic predict_digest(sha_item_t it);
        digest_beat_t beat;
        if (it.byte_present)
        begin
            place_byte(fill_bytes, it.data_byte);
            bit_count += 8;
            fill_bytes += 1;
            if (fill_bytes == 0)
            begin
                compress_block();
            end
        end
        if (it.end_of_message)
        begin
            place_byte(fill_bytes, 8'h80);
            for (int i = fill_bytes[5:2] + 1; i < 16; i++)
            begin
                msg_block[i] = '0;
            end
            if (fill_bytes >= 56)
            begin
                compress_block();
                for (int i = 0; i < 16; i++)
                begin
                    msg_block[i] = '0;
                end
            end
            msg_block[14] = bit_count[63:32];
            msg_block[15] = bit_count[31:0];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                beat.word = hash_state[i];
                beat.last = (i == 7);
                expected_words.insert(expected_words.size(), beat);
                hash_state[i] = init_hash(i[2:0]);
            end
            fill_bytes = '0;
            bit_count = '0;
        end
    endtask

    function automatic sha_item_t make_item(logic [7:0] b, logic p, logic e);
        sha_item_t it;
        it.data_byte = b;
        it.byte_present = p;
        it.end_of_message = e;
        return it;
    endfunction

    task automatic queue_item(sha_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_message(int len, bit pattern);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                queue_item(make_item(8'($urandom), 1'b0, 1'b0));
            end
            queue_item(make_item(pattern ? 8'(i) : 8'($urandom), 1'b1,
                (i == len - 1) && $urandom_range(0, 1)));
        end
        if (len == 0 || !pending_items[$].end_of_message)
        begin
            queue_item(make_item(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            s_axis_tlast <= 1'b0;
            src_gap <= 0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_items[0].data_byte;
                s_axis_tuser <= pending_items[0].byte_present;
                s_axis_tlast <= pending_items[0].end_of_message;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                begin
                    src_gap <= $urandom_range(1, 9);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire)
        begin
            predict_digest(pending_items.pop_front());
        end
    end

    // long receiver hold
    initial
    begin
        hold_sink = 1'b0;
        hold_done = 1'b0;
        wait (hold_go);
        hold_sink = 1'b1;
        repeat (600) @(posedge clk);
        hold_sink = 1'b0;
        hold_done = 1'b1;
    end

    // monitor
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end
        else if (hold_sink)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            sink_gap <= $urandom_range(1, 9);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected digest beat %h last %b", m_axis_tdata, m_axis_tlast);
                end
            end
            else
            begin
                exp_beat = expected_words.pop_front();
                if (m_axis_tdata !== exp_beat.word || m_axis_tlast !== exp_beat.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("digest mismatch: expected %h/%b got %h/%b",
                            exp_beat.word, exp_beat.last, m_axis_tdata, m_axis_tlast);
                    end
                end
                if (exp_beat.last)
                begin
                    messages_seen++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int total;
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = init_hash(i[2:0]);
        end
        for (int i = 0; i < 16; i++)
        begin
            msg_block[i] = '0;
        end
        fill_bytes = '0;
        bit_count = '0;
        mismatches = 0;
        words_checked = 0;
        messages_seen = 0;
        quiet_phase = 1'b0;
        hold_go = 1'b0;
        in_fire = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, idle beats, byte extremes, pad boundaries
        queue_item(make_item(8'hff, 1'b0, 1'b0));
        queue_item(make_item(8'h00, 1'b0, 1'b1));
        queue_item(make_item(8'h00, 1'b1, 1'b1));
        queue_item(make_item(8'hff, 1'b1, 1'b0));
        queue_item(make_item(8'haa, 1'b0, 1'b0));
        queue_item(make_item(8'h55, 1'b1, 1'b0));
        queue_item(make_item(8'h00, 1'b0, 1'b1));
        wait_drained();
        add_message(55, 1'b1);
        add_message(56, 1'b0);
        add_message(64, 1'b1);
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_go = 1'b1;
        add_message(3, 1'b0);
        add_message(1, 1'b0);
        add_message(2, 1'b0);
        add_message(0, 1'b0);
        add_message(5, 1'b0);
        wait (hold_done);
        wait_drained();

        total = 0;
        while (total < 150)
        begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
            add_message(len, 1'b0);
            total += len + 1;
            if (total > 110)
            begin
                wait_drained();
                quiet_phase = 1'b1;
            end
        end
        wait_drained();
        repeat (300) @(posedge clk);
        $display("checked %0d digest words over %0d messages", words_checked, messages_seen);
        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/sha256_pkg.sv
rtl/sha256_queue.sv
rtl/sha256_core.sv
rtl/sha256_message_digest.sv
sim/tb_sha256_message_digest.sv
